>>> sv/sjis_pkg.sv
`default_nettype none

package sjis_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRING_MODE = 4'd1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Byte classification
  localparam logic [7:0] ASCII_TOP   = 8'h80;
  localparam logic [7:0] LEAD_XOR    = 8'h20;
  localparam logic [7:0] LEAD_BASE   = 8'hA1;
  localparam logic [7:0] LEAD_SPAN   = 8'h2F;
  localparam logic [7:0] KANA_BASE   = 8'hA0;
  localparam logic [7:0] KANA_SPAN   = 8'h40;
  localparam logic [7:0] KANA_PREFIX = 8'h8E;

  // Trail byte arithmetic
  localparam logic [8:0]  TRAIL_ADD  = 9'h062;
  localparam logic [8:0]  TRAIL_BASE = 9'h0A2;
  localparam logic [15:0] TRAIL_OFS  = 16'h9FA1;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data;
    logic [CNT_OUT_W-1:0] count;
  } sjis_res_t;

  // Results caused by one source byte, packed from slot 0 upward
  typedef struct packed {
    logic [2:0]           num;
    sjis_res_t [3:0]      slot;
  } sjis_pack_t;

endpackage

`default_nettype wire

>>> sv/sjis_in_if.sv
`default_nettype none

interface sjis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       src_last;

  modport source (output valid, output in_byte, output src_last, input ready);
  modport sink   (input valid, input in_byte, input src_last, output ready);
endinterface

`default_nettype wire

>>> sv/sjis_out_if.sv
`default_nettype none

interface sjis_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] byte_count;
  logic        run_end;

  modport source (output valid, output kind, output out_byte, output byte_count,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input out_byte, input byte_count,
                  input run_end, output ready);
endinterface

`default_nettype wire

>>> sv/sjis_cfg_if.sv
`default_nettype none

interface sjis_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sjis_core.sv
`default_nettype none

module sjis_core #(
  parameter int unsigned COUNT_BITS = sjis_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 src_last,
  input  wire logic [15:0]          capacity,
  input  wire logic                 string_mode,
  input  wire logic                 advance,
  output sjis_pkg::sjis_pack_t      pack
);
  import sjis_pkg::*;

  logic                  in_buffer_r, in_buffer_nxt;
  logic                  unlimited_r, strmode_r;
  logic [15:0]           room_left_r, room_left_nxt;
  logic [COUNT_BITS-1:0] produced_r, produced_nxt;
  logic                  halted_r, halted_nxt;
  logic                  lead_pending_r, lead_pending_nxt;
  logic [7:0]            held_lead_r, held_lead_nxt;

  logic                  start, unl, sm, hlt, lp;
  logic [15:0]           room;
  logic [COUNT_BITS-1:0] prod;
  logic [7:0]            hl;
  logic                  fits1, fits2;
  logic [7:0]            lead_off, kana_off;
  logic [8:0]            c1, c2;
  logic [15:0]           c3;
  logic [7:0]            trail_hi;
  logic [1:0]            take_k;
  logic [1:0]            ndata;
  logic [7:0]            d0, d1;
  logic                  term;
  logic [COUNT_BITS:0]   sum_take, sum_term;
  logic [COUNT_BITS-1:0] cnt;
  logic [31:0]           cnt32;
  logic [15:0]           cnt_cap;
  sjis_res_t [3:0]       cand;
  logic [3:0]            cand_vld;
  logic [2:0]            n;

  // Conversion of one byte against the current run state
  always_comb begin
    start = !in_buffer_r;
    unl   = start ? (capacity == 16'd0) : unlimited_r;
    sm    = start ? string_mode : strmode_r;
    room  = start ? (unl ? 16'd0 : capacity - 16'(string_mode)) : room_left_r;
    prod  = start ? '0 : produced_r;
    hlt   = start ? 1'b0 : halted_r;
    lp    = start ? 1'b0 : lead_pending_r;
    hl    = start ? 8'd0 : held_lead_r;

    fits1 = unl || (room != 16'd0);
    fits2 = unl || (room >= 16'd2);

    lead_off = (in_byte ^ LEAD_XOR) - LEAD_BASE;
    kana_off = in_byte - KANA_BASE;

    c1 = 9'(in_byte) + TRAIL_ADD - 9'(in_byte[7]);
    c2 = c1[8] ? c1 : c1 - TRAIL_BASE;
    c3 = 16'(c2) + TRAIL_OFS;
    trail_hi = {1'b0, hl[5:0], 1'b0} + c3[15:8];

    take_k           = 2'd0;
    ndata            = 2'd0;
    d0               = in_byte;
    d1               = in_byte;
    halted_nxt       = hlt;
    lead_pending_nxt = lp;
    held_lead_nxt    = hl;

    if (!hlt) begin
      priority if (lp) begin
        lead_pending_nxt = 1'b0;
        if (in_byte == 8'd0 || !fits2) begin
          halted_nxt = 1'b1;
        end else begin
          take_k = 2'd2;
          ndata  = unl ? 2'd0 : 2'd2;
          d0     = trail_hi;
          d1     = c3[7:0];
        end
      end else if (in_byte == 8'd0 && sm) begin
        halted_nxt = 1'b1;
      end else if (in_byte < ASCII_TOP) begin
        if (!fits1) begin
          halted_nxt = 1'b1;
        end else begin
          take_k = 2'd1;
          ndata  = unl ? 2'd0 : 2'd1;
        end
      end else if (lead_off < LEAD_SPAN) begin
        if (src_last) begin
          halted_nxt = 1'b1;
        end else begin
          held_lead_nxt    = in_byte;
          lead_pending_nxt = 1'b1;
        end
      end else if (kana_off < KANA_SPAN) begin
        if (!fits2) begin
          halted_nxt = 1'b1;
        end else begin
          take_k = 2'd2;
          ndata  = unl ? 2'd0 : 2'd2;
          d0     = KANA_PREFIX;
        end
      end else begin
        // any other byte: drop it
      end
    end

    room_left_nxt = unl ? room : room - 16'(take_k);
    sum_take      = {1'b0, prod} + (COUNT_BITS+1)'(take_k);
    produced_nxt  = sum_take[COUNT_BITS] ? '1 : sum_take[COUNT_BITS-1:0];

    // Terminator reservation is added to the count only in string mode
    sum_term = {1'b0, produced_nxt} + (COUNT_BITS+1)'(1);
    cnt      = (sm && !sum_term[COUNT_BITS]) ? sum_term[COUNT_BITS-1:0] :
               (sm ? '1 : produced_nxt);
    cnt32    = 32'(cnt);
    cnt_cap  = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];

    term          = src_last && !unl && (sm || room_left_nxt != 16'd0);
    in_buffer_nxt = !src_last;
    if (src_last) begin
      lead_pending_nxt = 1'b0;
      halted_nxt       = 1'b0;
    end

    cand[0]     = '{kind: KIND_DATA, data: d0, count: 16'd0};
    cand[1]     = '{kind: KIND_DATA, data: d1, count: 16'd0};
    cand[2]     = '{kind: KIND_TERM, data: 8'd0, count: 16'd0};
    cand[3]     = '{kind: KIND_DONE, data: 8'd0, count: cnt_cap};
    cand_vld[0] = (ndata != 2'd0);
    cand_vld[1] = (ndata == 2'd2);
    cand_vld[2] = term;
    cand_vld[3] = src_last;

    // Compact the candidates into consecutive slots
    n         = 3'd0;
    pack.slot = cand;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i]) begin
        pack.slot[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    pack.num = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_buffer_r    <= 1'b0;
      unlimited_r    <= 1'b0;
      strmode_r      <= 1'b0;
      room_left_r    <= 16'd0;
      produced_r     <= '0;
      halted_r       <= 1'b0;
      lead_pending_r <= 1'b0;
      held_lead_r    <= 8'd0;
    end else if (advance) begin
      in_buffer_r    <= in_buffer_nxt;
      unlimited_r    <= unl;
      strmode_r      <= sm;
      room_left_r    <= room_left_nxt;
      produced_r     <= produced_nxt;
      halted_r       <= halted_nxt;
      lead_pending_r <= lead_pending_nxt;
      held_lead_r    <= held_lead_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/sjis_emit.sv
`default_nettype none

module sjis_emit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire sjis_pkg::sjis_pack_t pack,
  output logic                 load_ok,
  sjis_out_if.source           out_ch
);
  import sjis_pkg::*;

  sjis_res_t  slot_r [4];
  logic [2:0] num_r;
  logic [1:0] ptr_r;
  logic       beat;

  assign beat    = out_ch.valid && out_ch.ready;
  // Take a new group when nothing is left or the last result leaves now
  assign load_ok = (num_r == 3'd0) || (num_r == 3'd1 && out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= 3'd0;
      ptr_r <= 2'd0;
    end else if (load) begin
      num_r <= pack.num;
      ptr_r <= 2'd0;
    end else if (beat) begin
      num_r <= num_r - 3'd1;
      ptr_r <= ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        slot_r[i] <= pack.slot[i];
      end
    end
  end

  assign out_ch.valid      = (num_r != 3'd0);
  assign out_ch.kind       = slot_r[ptr_r].kind;
  assign out_ch.out_byte   = slot_r[ptr_r].data;
  assign out_ch.byte_count = slot_r[ptr_r].count;
  assign out_ch.run_end    = (num_r == 3'd1);

endmodule

`default_nettype wire

>>> sv/sjis_to_eucjp_converter.sv
// Path: a source byte is registered in the input stage, then its results in the result bank.
// Throughput: one source byte per cycle while each byte gives at most one result
//   and results are taken; a byte with k results (up to 4) holds the port until
//   all k have left. The result serializer, one result per beat, sets that rate.
// Reset: synchronous, active low; clears the run state, the configuration and
//   all valid flags.
`default_nettype none

module sjis_to_eucjp_converter #(
  parameter int unsigned COUNT_BITS = sjis_pkg::COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sjis_in_if.sink    in_ch,
  sjis_out_if.source out_ch,
  sjis_cfg_if.sink   cfg_ch
);
  import sjis_pkg::*;

  // Configuration registers. They are sampled by the core at the first byte
  // of each run, so a write during a run only shows at the next one.
  logic [15:0] capacity_r;
  logic        string_mode_r;

  // Input stage: one source byte waiting for the converter.
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  logic        load_ok;
  logic        advance;
  sjis_pack_t  pack;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= 16'd0;
      string_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CAPACITY:    capacity_r    <= cfg_ch.data;
        REG_STRING_MODE: string_mode_r <= cfg_ch.data[0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Advance the held byte when the serializer can take its results. The
  // input stage refills in the same cycle, so a byte enters every cycle as
  // long as results keep draining.
  assign advance     = in_vld_r && load_ok;
  assign in_ch.ready = !in_vld_r || load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // Hold the payload while the stage is full
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.src_last;
    end
  end

  // Classification, trail arithmetic, capacity and count bookkeeping; the
  // run state moves only when the byte advances.
  sjis_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_byte_r),
    .src_last    (in_last_r),
    .capacity    (capacity_r),
    .string_mode (string_mode_r),
    .advance     (advance),
    .pack        (pack)
  );

  // Result register bank: hands the group out one beat at a time and marks
  // the last beat of the group with run_end. A byte that yields nothing
  // loads an empty group and passes straight through.
  sjis_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .pack    (pack),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> sv/sjis_checker.sv
`default_nettype none

module sjis_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [15:0] out_count,
  input wire logic        out_run_end
);
  import sjis_pkg::*;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_byte) && $stable(out_count) && $stable(out_run_end))
    else $error("result beat changed while stalled");

  // Done closes the group of its byte
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_run_end && out_byte == 8'd0)
    else $error("done beat not last of its group");

  // A terminator is always followed by done in the same group
  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_TERM |->
      !out_run_end && out_byte == 8'd0 && out_count == 16'd0 ##1
      out_valid && out_kind == KIND_DONE)
    else $error("terminator not followed by done");

  // Data beats carry no count
  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_count == 16'd0)
    else $error("data beat with nonzero count");

endmodule

bind sjis_to_eucjp_converter sjis_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_byte    (out_ch.out_byte),
  .out_count   (out_ch.byte_count),
  .out_run_end (out_ch.run_end)
);

`default_nettype wire
